// File: sv/jpoe_pkg.sv
// Shared types and constants for the JSON payload object extractor.
package jpoe_pkg;

    localparam int DEPTH_BITS_DEF = 8;
    localparam int WINDOW_LEN     = 9;

    // Key without its trailing colon; oldest byte sits in the top bits.
    localparam logic [8*WINDOW_LEN-1:0] KEY_HEAD  = "\"payload\"";
    localparam logic [7:0]              CH_COLON  = ":";
    localparam logic [7:0]              CH_SPACE  = " ";
    localparam logic [7:0]              CH_TAB    = 8'h09;
    localparam logic [7:0]              CH_OPEN   = "{";
    localparam logic [7:0]              CH_CLOSE  = "}";
    localparam logic [7:0]              CH_QUOTE  = "\"";
    localparam logic [7:0]              CH_BSLASH = 8'h5c;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_BLANK  = 2'd1,
        PH_OBJECT = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_WORK = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef struct packed {
        logic    keep;
        logic    object_end;
        t_status status;
    } t_result;

endpackage

// File: sv/jpoe_if.sv
// Handshake channels for line bytes in and marked bytes out.
interface jpoe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       line_last;

    modport source (output valid, output line_byte, output line_last, input ready);
    modport sink (input valid, input line_byte, input line_last, output ready);
endinterface

interface jpoe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] echo_byte;
    logic       keep;
    logic       object_end;
    logic [1:0] status;

    modport source (output valid, output echo_byte, output keep, output object_end,
                    output status, input ready);
    modport sink (input valid, input echo_byte, input keep, input object_end,
                  input status, output ready);
endinterface

// File: sv/jpoe_window.sv
// Window of recent bytes and key detector.
module jpoe_window (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_searching,
    input  logic       i_last,
    input  logic [7:0] i_byte,
    output logic       o_key_hit
);
    localparam int WinW = 8 * jpoe_pkg::WINDOW_LEN;

    logic [WinW-1:0] r_win;
    logic [WinW-1:0] n_win;

    assign n_win     = {r_win[WinW-9:0], i_byte};
    assign o_key_hit = (i_byte == jpoe_pkg::CH_COLON) && (r_win == jpoe_pkg::KEY_HEAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_step) begin
            // Start each line with an empty window.
            if (i_last) begin
                r_win <= '0;
            end else if (i_searching) begin
                r_win <= n_win;
            end
        end
    end
endmodule

// File: sv/jpoe_scan.sv
// Phase, brace depth and string tracking with per-byte result decode.
module jpoe_scan #(
    parameter int DEPTH_BITS = jpoe_pkg::DEPTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_key_hit,
    output logic              o_searching,
    output jpoe_pkg::t_result o_result
);
    jpoe_pkg::t_phase  r_phase, n_phase;
    jpoe_pkg::t_status r_verdict, n_verdict;
    logic [DEPTH_BITS-1:0] r_depth, n_depth, depth_dec;
    logic r_in_str, n_in_str;
    logic r_esc, n_esc;

    logic is_blank, is_open, is_close, is_quote, is_bslash, depth_full;

    assign is_blank    = (i_byte == jpoe_pkg::CH_SPACE) || (i_byte == jpoe_pkg::CH_TAB);
    assign is_open     = (i_byte == jpoe_pkg::CH_OPEN);
    assign is_close    = (i_byte == jpoe_pkg::CH_CLOSE);
    assign is_quote    = (i_byte == jpoe_pkg::CH_QUOTE);
    assign is_bslash   = (i_byte == jpoe_pkg::CH_BSLASH);
    assign depth_full  = &r_depth;
    assign depth_dec   = r_depth - DEPTH_BITS'(1);
    assign o_searching = (r_phase == jpoe_pkg::PH_SEARCH);

    // Next state, before the end-of-line clear.
    always_comb begin
        n_phase   = r_phase;
        n_verdict = r_verdict;
        n_depth   = r_depth;
        n_in_str  = r_in_str;
        n_esc     = r_esc;
        case (r_phase)
            jpoe_pkg::PH_SEARCH: begin
                if (i_key_hit) begin
                    n_phase = jpoe_pkg::PH_BLANK;
                end
            end
            jpoe_pkg::PH_BLANK: begin
                if (is_blank) begin
                    n_phase = jpoe_pkg::PH_BLANK;
                end else if (is_open) begin
                    n_phase  = jpoe_pkg::PH_OBJECT;
                    n_depth  = DEPTH_BITS'(1);
                    n_in_str = 1'b0;
                    n_esc    = 1'b0;
                end else begin
                    n_phase   = jpoe_pkg::PH_DONE;
                    n_verdict = jpoe_pkg::ST_FAIL;
                end
            end
            jpoe_pkg::PH_OBJECT: begin
                if (r_in_str) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (is_bslash) begin
                        n_esc = 1'b1;
                    end else if (is_quote) begin
                        n_in_str = 1'b0;
                    end
                end else if (is_quote) begin
                    n_in_str = 1'b1;
                end else if (is_open) begin
                    if (depth_full) begin
                        n_phase   = jpoe_pkg::PH_DONE;
                        n_verdict = jpoe_pkg::ST_FAIL;
                    end else begin
                        n_depth = r_depth + DEPTH_BITS'(1);
                    end
                end else if (is_close) begin
                    n_depth = depth_dec;
                    if (depth_dec == '0) begin
                        n_phase   = jpoe_pkg::PH_DONE;
                        n_verdict = jpoe_pkg::ST_OK;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result for the current byte.
    always_comb begin
        o_result.keep       = 1'b0;
        o_result.object_end = 1'b0;
        o_result.status     = jpoe_pkg::ST_WORK;
        case (r_phase)
            jpoe_pkg::PH_SEARCH: begin
                o_result.keep = 1'b0;
            end
            jpoe_pkg::PH_BLANK: begin
                if (is_open) begin
                    o_result.keep = 1'b1;
                end else if (!is_blank) begin
                    o_result.status = jpoe_pkg::ST_FAIL;
                end
            end
            jpoe_pkg::PH_OBJECT: begin
                if (!r_in_str && !is_quote && is_open && depth_full) begin
                    o_result.status = jpoe_pkg::ST_FAIL;
                end else begin
                    o_result.keep = 1'b1;
                end
                if (!r_in_str && is_close && depth_dec == '0) begin
                    o_result.object_end = 1'b1;
                    o_result.status     = jpoe_pkg::ST_OK;
                end
            end
            default: begin
                o_result.status = r_verdict;
            end
        endcase
        // Fail a line that ends before the object closes, also one in which the key was never found.
        if (i_last && n_phase != jpoe_pkg::PH_DONE) begin
            o_result.keep   = 1'b0;
            o_result.status = jpoe_pkg::ST_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jpoe_pkg::PH_SEARCH;
            r_verdict <= jpoe_pkg::ST_WORK;
            r_depth   <= '0;
            r_in_str  <= 1'b0;
            r_esc     <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase   <= jpoe_pkg::PH_SEARCH;
                r_verdict <= jpoe_pkg::ST_WORK;
                r_depth   <= '0;
                r_in_str  <= 1'b0;
                r_esc     <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_verdict <= n_verdict;
                r_depth   <= n_depth;
                r_in_str  <= n_in_str;
                r_esc     <= n_esc;
            end
        end
    end
endmodule

// File: sv/json_payload_object_extractor_core.sv
// A byte accepted into the core shows its result from the result register in the cycle after.
// Throughput: one byte per cycle while the output side is ready; the result register frees as soon as it is taken,
// and a new byte is taken in the same cycle the held result leaves.
// Reset (synchronous, active low) empties the result register, clears the key window
// and returns the scanner to key search; window and scanner clear the same way after every line's last byte.
module json_payload_object_extractor_core #(
    parameter int DEPTH_BITS = jpoe_pkg::DEPTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jpoe_in_if.sink           i_line,
    jpoe_out_if.source        o_result
);
    logic              step;
    logic              searching;
    logic              key_hit;
    jpoe_pkg::t_result res;

    logic              r_out_valid;
    logic [7:0]        r_byte;
    jpoe_pkg::t_result r_res;

    assign i_line.ready = !r_out_valid || o_result.ready;
    assign step         = i_line.valid && i_line.ready;

    jpoe_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_searching (searching),
        .i_last      (i_line.line_last),
        .i_byte      (i_line.line_byte),
        .o_key_hit   (key_hit)
    );

    jpoe_scan #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (i_line.line_byte),
        .i_last      (i_line.line_last),
        .i_key_hit   (key_hit),
        .o_searching (searching),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= i_line.line_byte;
            r_res  <= res;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.echo_byte  = r_byte;
    assign o_result.keep       = r_res.keep;
    assign o_result.object_end = r_res.object_end;
    assign o_result.status     = r_res.status;

    a_end_is_kept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.object_end)
            |-> (o_result.keep && o_result.status == jpoe_pkg::ST_OK))
        else $error("object end without keep and ok status");

    a_keep_not_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.keep) |-> (o_result.status != jpoe_pkg::ST_FAIL))
        else $error("kept byte carries failed status");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_line.line_last) |=> searching)
        else $error("scanner not back in key search after line end");

    a_hit_only_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && key_hit && searching && !i_line.line_last) |=> !searching)
        else $error("key hit did not leave key search");
endmodule

// File: bench/json_payload_object_extractor_core_tb.sv
// Testbench for the JSON payload object extractor: directed and random lines checked per byte.
module json_payload_object_extractor_core_tb;

    localparam int DEPTH_BITS  = jpoe_pkg::DEPTH_BITS_DEF;
    localparam int WIN_W       = 8 * jpoe_pkg::WINDOW_LEN;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 560;
    localparam int CALM_ITEMS   = 200;

    typedef struct {
        logic [7:0]        echo_byte;
        logic              keep;
        logic              object_end;
        jpoe_pkg::t_status status;
    } t_marked_byte;

    logic i_clk;
    logic i_rst_n;

    jpoe_in_if  line_if ();
    jpoe_out_if res_if ();

    json_payload_object_extractor_core #(
        .DEPTH_BITS(DEPTH_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_if),
        .o_result(res_if)
    );

    // scanner copy used for prediction
    logic [WIN_W-1:0]      key_win;
    jpoe_pkg::t_phase      scan_phase;
    logic [DEPTH_BITS-1:0] obj_depth;
    logic                  in_quote;
    logic                  escape_next;
    jpoe_pkg::t_status     line_verdict;

    t_marked_byte marked_q[$];
    logic [7:0]   line_buf[$];
    int           fail_cnt = 0;
    int           byte_cnt;
    int           cycle_cnt = 0;
    int           stall_left = 0;
    bit           idle_en;
    bit           stall_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("json_payload_object_extractor_core_tb NOT OK");
            $finish;
        end
    end

    function automatic void clear_scan();
        key_win      = '0;
        scan_phase   = jpoe_pkg::PH_SEARCH;
        obj_depth    = '0;
        in_quote     = 1'b0;
        escape_next  = 1'b0;
        line_verdict = jpoe_pkg::ST_WORK;
    endfunction

    function automatic void predict_marked_byte(input logic [7:0] b, input logic last);
        t_marked_byte m;
        logic         fail;
        m.echo_byte  = b;
        m.keep       = 1'b0;
        m.object_end = 1'b0;
        m.status     = jpoe_pkg::ST_WORK;
        fail         = 1'b0;
        case (scan_phase)
            jpoe_pkg::PH_SEARCH: begin
                if (b == jpoe_pkg::CH_COLON && key_win == jpoe_pkg::KEY_HEAD) begin
                    scan_phase = jpoe_pkg::PH_BLANK;
                end
                key_win = {key_win[WIN_W-9:0], b};
            end
            jpoe_pkg::PH_BLANK: begin
                if (b == jpoe_pkg::CH_OPEN) begin
                    scan_phase  = jpoe_pkg::PH_OBJECT;
                    obj_depth   = DEPTH_BITS'(1);
                    in_quote    = 1'b0;
                    escape_next = 1'b0;
                    m.keep      = 1'b1;
                end else if (b != jpoe_pkg::CH_SPACE && b != jpoe_pkg::CH_TAB) begin
                    fail = 1'b1;
                end
            end
            jpoe_pkg::PH_OBJECT: begin
                if (in_quote) begin
                    m.keep = 1'b1;
                    if (escape_next) escape_next = 1'b0;
                    else if (b == jpoe_pkg::CH_BSLASH) escape_next = 1'b1;
                    else if (b == jpoe_pkg::CH_QUOTE) in_quote = 1'b0;
                end else if (b == jpoe_pkg::CH_QUOTE) begin
                    m.keep   = 1'b1;
                    in_quote = 1'b1;
                end else if (b == jpoe_pkg::CH_OPEN) begin
                    if (obj_depth == '1) begin
                        fail = 1'b1;
                    end else begin
                        obj_depth = obj_depth + 1'b1;
                        m.keep    = 1'b1;
                    end
                end else if (b == jpoe_pkg::CH_CLOSE) begin
                    m.keep    = 1'b1;
                    obj_depth = obj_depth - 1'b1;
                    if (obj_depth == '0) begin
                        m.object_end = 1'b1;
                        m.status     = jpoe_pkg::ST_OK;
                        line_verdict = jpoe_pkg::ST_OK;
                        scan_phase   = jpoe_pkg::PH_DONE;
                    end
                end else begin
                    m.keep = 1'b1;
                end
            end
            default: m.status = line_verdict;
        endcase
        if (fail) begin
            m.keep       = 1'b0;
            m.status     = jpoe_pkg::ST_FAIL;
            line_verdict = jpoe_pkg::ST_FAIL;
            scan_phase   = jpoe_pkg::PH_DONE;
        end
        if (last && scan_phase != jpoe_pkg::PH_DONE) begin
            m.keep   = 1'b0;
            m.status = jpoe_pkg::ST_FAIL;
        end
        marked_q.push_back(m);
        if (last) clear_scan();
    endfunction

    // output side: random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_marked_byte m;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (marked_q.size() == 0) begin
                $error("result with nothing expected: byte %02h", res_if.echo_byte);
                fail_cnt++;
            end else begin
                m = marked_q.pop_front();
                if (res_if.echo_byte !== m.echo_byte) begin
                    $error("echo_byte: expected %02h, got %02h", m.echo_byte, res_if.echo_byte);
                    fail_cnt++;
                end
                if (res_if.keep !== m.keep) begin
                    $error("keep: expected %0d, got %0d", m.keep, res_if.keep);
                    fail_cnt++;
                end
                if (res_if.object_end !== m.object_end) begin
                    $error("object_end: expected %0d, got %0d", m.object_end,
                           res_if.object_end);
                    fail_cnt++;
                end
                if (res_if.status !== m.status) begin
                    $error("status: expected %0d, got %0d", m.status, res_if.status);
                    fail_cnt++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            line_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        line_if.valid     <= 1'b1;
        line_if.line_byte <= b;
        line_if.line_last <= last;
        do @(posedge i_clk); while (!line_if.ready);
        predict_marked_byte(b, last);
        byte_cnt++;
        @(negedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic add_random(input int n);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic test_byte_extremes();
        line_buf.push_back(8'h00);
        send_line();
        line_buf.push_back(8'hff);
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hff);
        send_line();
        add_text("{");
        send_line();
    endtask

    task automatic test_key_search();
        add_text("xx\"payload\":{\"k\":1}tail");
        send_line();
        add_text("\"payload\"x:{}");
        send_line();
        add_text("\"\"payload\":{}");
        send_line();
        // key split over two lines must not match
        add_text("\"payl");
        send_line();
        add_text("oad\":{}");
        send_line();
        add_text("\"payload\":{}\"payload\":{}");
        send_line();
    endtask

    task automatic test_blank_skip();
        add_text("\"payload\": \t {}");
        send_line();
        add_text("\"payload\": x{}");
        send_line();
        add_text("\"payload\":\t ");
        send_line();
    endtask

    task automatic test_strings_escapes();
        add_text("\"payload\":{\"a\\\"}\":\"{\\\\\"}");
        send_line();
    endtask

    task automatic test_unfinished_object();
        add_text("\"payload\":{{}");
        send_line();
    endtask

    task automatic test_depth_overflow();
        add_text("\"payload\":");
        repeat (1 << DEPTH_BITS) add_text("{");
        add_text("}}x");
        send_line();
    endtask

    // mostly well-formed lines with random content, some noise and broken ones
    task automatic send_random_line();
        int kind;
        int depth;
        int pos;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            add_random($urandom_range(1, 20));
            send_line();
            return;
        end
        add_random($urandom_range(0, 4));
        add_text("\"payload\":");
        if (kind == 1) begin
            pos = line_buf.size() - 1 - $urandom_range(0, 9);
            line_buf[pos] = 8'($urandom_range(0, 255));
        end
        repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(0, 1) ? jpoe_pkg::CH_SPACE : jpoe_pkg::CH_TAB);
        if (kind == 2) add_random(1);
        line_buf.push_back(jpoe_pkg::CH_OPEN);
        depth = 1;
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if (depth < 6) begin
                        line_buf.push_back(jpoe_pkg::CH_OPEN);
                        depth++;
                    end
                end
                2, 3: begin
                    if (depth > 1) begin
                        line_buf.push_back(jpoe_pkg::CH_CLOSE);
                        depth--;
                    end
                end
                4, 5: begin
                    line_buf.push_back(jpoe_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 4) == 0) begin
                            line_buf.push_back(jpoe_pkg::CH_BSLASH);
                            add_random(1);
                        end else begin
                            c = 8'($urandom_range(0, 255));
                            if (c == jpoe_pkg::CH_QUOTE || c == jpoe_pkg::CH_BSLASH) begin
                                c = "q";
                            end
                            line_buf.push_back(c);
                        end
                    end
                    line_buf.push_back(jpoe_pkg::CH_QUOTE);
                end
                9: add_random(1);
                default: begin
                    if ($urandom_range(0, 1)) add_text("a1");
                    else add_text(", :");
                end
            endcase
        end
        if ($urandom_range(0, 19) < 17) repeat (depth) line_buf.push_back(jpoe_pkg::CH_CLOSE);
        add_random($urandom_range(0, 3));
        send_line();
    endtask

    task automatic test_random_lines();
        int stop_at;
        stop_at = byte_cnt + RANDOM_ITEMS;
        while (byte_cnt < stop_at) send_random_line();
    endtask

    task automatic test_back_to_back();
        int stop_at;
        idle_en  = 1'b0;
        stall_en = 1'b0;
        stop_at  = byte_cnt + CALM_ITEMS;
        while (byte_cnt < stop_at) send_random_line();
    endtask

    initial begin
        byte_cnt   = 0;
        idle_en    = 1'b1;
        stall_en   = 1'b1;
        clear_scan();
        i_rst_n           = 1'b0;
        line_if.valid     = 1'b0;
        line_if.line_byte = '0;
        line_if.line_last = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_byte_extremes();
        test_key_search();
        test_blank_skip();
        test_strings_escapes();
        test_unfinished_object();
        test_depth_overflow();
        test_random_lines();
        test_back_to_back();

        line_if.valid <= 1'b0;
        while (marked_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("json_payload_object_extractor_core_tb OK");
        end else begin
            $display("json_payload_object_extractor_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/jpoe_pkg.sv
sv/jpoe_if.sv
sv/jpoe_window.sv
sv/jpoe_scan.sv
sv/json_payload_object_extractor_core.sv
bench/json_payload_object_extractor_core_tb.sv
